@@ design/lbua_pkg.sv @@
// package for the lru binding unit allocator
// types, sizes and command codes shared by every file of the block
`timescale 1ns / 1ps
package lbua_pkg;

    // sizes
    localparam int UNIT_COUNT     = 16;
    localparam int RESOURCE_COUNT = 256;
    localparam int UNIT_W         = $clog2(UNIT_COUNT);
    localparam int ID_W           = $clog2(RESOURCE_COUNT);
    localparam int STAMP_W        = 32;
    localparam int CNT_W          = $clog2(UNIT_COUNT);

    // payload field widths as seen on the ports
    localparam int FLD_ID_W   = 8;
    localparam int FLD_UNIT_W = 4;

    // command codes
    localparam logic CMD_ANY  = 1'b0;
    localparam logic CMD_UNIT = 1'b1;

    // input transfer payload
    typedef struct packed {
        logic                  command;
        logic [FLD_ID_W-1:0]   resource_id;
        logic [FLD_UNIT_W-1:0] target_unit;
    } t_in;

    // output transfer payload
    typedef struct packed {
        logic [FLD_UNIT_W-1:0] unit_used;
        logic                  select_issued;
        logic                  bind_issued;
        logic                  evicted_valid;
        logic [FLD_ID_W-1:0]   evicted_id;
    } t_out;

    // write controls broadcast to the unit cells
    typedef struct packed {
        logic               stamp_we;
        logic               occ_we;
        logic [STAMP_W-1:0] stamp;
        logic [ID_W-1:0]    id;
    } t_cell_wr;

    // occupant of one unit
    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
    } t_occ;

    // running minimum handed along the cell chain
    typedef struct packed {
        logic               valid;
        logic [STAMP_W-1:0] stamp;
        logic [UNIT_W-1:0]  idx;
    } t_best;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_BIND
    } t_state;

endpackage

@@ design/lru_binding_unit_allocator.sv @@
// lru binding unit allocator: top level with sequencer, resource table and output register
// depends on lbua_pkg and lbua_cell_row
//
// usage
//   input channel i_in_valid / o_in_ready carries one bind request (command,
//   resource id, target unit); output channel o_out_valid / i_out_ready carries
//   one result per request.
//   a request is taken only while the sequencer is idle; one request is in work
//   at a time.
//   a bind to a given unit or a reuse of a bound id goes from the look step
//   straight to the bind step; when a victim is searched, a scan step lies between
//   them, its length set by the stamp minimum that walks one cell of the unit chain per cycle.
//   reset clears all occupants, stamps, bound flags and the selected unit and
//   loads the stamp counter with one; no clearing pass is needed.
//   a stalled receiver holds the result in the output register; the next
//   request is still taken and worked up to its final update step, which
//   waits until the register is free.
`timescale 1ns / 1ps
module lru_binding_unit_allocator import lbua_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    t_state r_state;
    t_state n_state;

    // request registers
    logic              r_cmd;
    logic [ID_W-1:0]   r_id;
    logic [UNIT_W-1:0] r_target;
    logic [UNIT_W-1:0] r_rec_unit;
    logic [UNIT_W-1:0] r_unit;
    logic              r_stamp_only;
    logic [CNT_W-1:0]  r_scan_cnt;

    // architectural state
    logic [RESOURCE_COUNT-1:0] r_bound;
    logic [RESOURCE_COUNT-1:0] n_bound;
    logic [UNIT_W-1:0]         r_unit_mem [RESOURCE_COUNT];
    logic [UNIT_W-1:0]         r_sel;
    logic [STAMP_W-1:0]        r_stamp_cnt;

    // output register
    logic r_out_valid;
    t_out r_out;

    // sequencer outputs
    logic in_xfer;
    logic look_go;
    logic scan_run;
    logic scan_last;
    logic bind_go;
    logic out_free;

    // bind step
    t_cell_wr          w_wr;
    t_occ              w_occ;
    logic [UNIT_W-1:0] w_victim;
    logic              evict;
    logic              id_bound_after;
    logic              do_bind;
    logic              sel_change;

    assign out_free  = !r_out_valid || i_out_ready;
    assign scan_last = (r_scan_cnt == CNT_W'(UNIT_COUNT - 1));
    assign in_xfer   = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_LOOK;
            end
            S_LOOK: begin
                if (r_cmd == CMD_UNIT || r_bound[r_id]) n_state = S_BIND;
                else n_state = S_SCAN;
            end
            S_SCAN: begin
                if (scan_last) n_state = S_BIND;
            end
            S_BIND: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        look_go    = 1'b0;
        scan_run   = 1'b0;
        bind_go    = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_LOOK:  look_go    = 1'b1;
            S_SCAN:  scan_run   = 1'b1;
            S_BIND:  bind_go    = out_free;
            default: o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // unit cells
    lbua_cell_row u_row (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_unit   (r_unit),
        .i_wr     (w_wr),
        .o_occ    (w_occ),
        .o_victim (w_victim)
    );

    // bind step decisions; the occupant is unbound before the record check
    always_comb begin
        evict          = !r_stamp_only && w_occ.valid;
        id_bound_after = r_bound[r_id] && !(evict && (w_occ.id == r_id));
        do_bind        = !r_stamp_only && !(id_bound_after && (r_rec_unit == r_unit));
        sel_change     = (r_unit != r_sel);
        w_wr.stamp_we  = bind_go;
        w_wr.occ_we    = bind_go && do_bind;
        w_wr.stamp     = r_stamp_cnt;
        w_wr.id        = r_id;
    end

    // bound flags after the bind step: old occupant cleared, then requester set
    always_comb begin
        n_bound = r_bound;
        if (evict) begin
            n_bound[w_occ.id] = 1'b0;
        end
        if (do_bind) begin
            n_bound[r_id] = 1'b1;
        end
    end

    // request capture and unit choice
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd    <= i_in.command;
            r_id     <= i_in.resource_id[ID_W-1:0];
            r_target <= i_in.target_unit[UNIT_W-1:0];
        end
        if (look_go) begin
            r_scan_cnt <= '0;
            if (r_cmd == CMD_UNIT) begin
                r_unit       <= r_target;
                r_stamp_only <= 1'b0;
            end else begin
                r_unit       <= r_rec_unit;
                r_stamp_only <= r_bound[r_id];
            end
        end
        if (scan_run) begin
            r_scan_cnt <= r_scan_cnt + CNT_W'(1);
            if (scan_last) begin
                r_unit <= w_victim;
            end
        end
    end

    // resource-to-unit table, read at the request transfer
    always_ff @(posedge i_clk) begin
        if (bind_go && do_bind) begin
            r_unit_mem[r_id] <= r_unit;
        end
        if (in_xfer) begin
            r_rec_unit <= r_unit_mem[i_in.resource_id[ID_W-1:0]];
        end
    end

    // bound flags, selected unit and stamp counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound     <= '0;
            r_sel       <= '0;
            r_stamp_cnt <= STAMP_W'(1);
        end else if (bind_go) begin
            r_bound     <= n_bound;
            r_sel       <= r_unit;
            r_stamp_cnt <= r_stamp_cnt + STAMP_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (bind_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (bind_go) begin
            r_out.unit_used     <= FLD_UNIT_W'(r_unit);
            r_out.select_issued <= sel_change;
            r_out.bind_issued   <= do_bind;
            r_out.evicted_valid <= evict;
            r_out.evicted_id    <= evict ? FLD_ID_W'(w_occ.id) : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ design/lbua_cell.sv @@
// one binding unit: occupant, last-use stamp and one stage of the victim chain
// depends on lbua_pkg
`timescale 1ns / 1ps
module lbua_cell import lbua_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [UNIT_W-1:0] i_index,
    input  logic              i_sel,
    input  t_cell_wr          i_wr,
    input  t_best             i_best,
    output t_occ              o_occ,
    output t_best             o_best
);

    logic               r_occ_valid;
    logic [ID_W-1:0]    r_occ_id;
    logic [STAMP_W-1:0] r_stamp;
    t_best              r_best;
    t_best              n_best;

    // control state and stamps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ_valid <= 1'b0;
            r_stamp     <= '0;
            r_best      <= '0;
        end else begin
            if (i_sel && i_wr.occ_we) begin
                r_occ_valid <= 1'b1;
            end
            if (i_sel && i_wr.stamp_we) begin
                r_stamp <= i_wr.stamp;
            end
            r_best <= n_best;
        end
    end

    // occupant id
    always_ff @(posedge i_clk) begin
        if (i_sel && i_wr.occ_we) begin
            r_occ_id <= i_wr.id;
        end
    end

    // keep the incoming minimum on a tie so the lower index wins
    always_comb begin
        if (!i_best.valid || (r_stamp < i_best.stamp)) begin
            n_best.valid = 1'b1;
            n_best.stamp = r_stamp;
            n_best.idx   = i_index;
        end else begin
            n_best = i_best;
        end
    end

    assign o_occ.valid = r_occ_valid;
    assign o_occ.id    = r_occ_id;
    assign o_best      = r_best;

endmodule

@@ design/lbua_cell_row.sv @@
// row of unit cells chained for the least-recently-used search
// depends on lbua_pkg and lbua_cell
`timescale 1ns / 1ps
module lbua_cell_row import lbua_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [UNIT_W-1:0] i_unit,
    input  t_cell_wr          i_wr,
    output t_occ              o_occ,
    output logic [UNIT_W-1:0] o_victim
);

    t_best w_chain [UNIT_COUNT+1];
    t_occ  w_occ   [UNIT_COUNT];

    // chain head carries no candidate
    assign w_chain[0] = '0;

    for (genvar g = 0; g < UNIT_COUNT; g++) begin : g_cell
        lbua_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (UNIT_W'(g)),
            .i_sel   (i_unit == UNIT_W'(g)),
            .i_wr    (i_wr),
            .i_best  (w_chain[g]),
            .o_occ   (w_occ[g]),
            .o_best  (w_chain[g+1])
        );
    end

    // occupant of the addressed unit and the chain result
    assign o_occ    = w_occ[i_unit];
    assign o_victim = w_chain[UNIT_COUNT].idx;

endmodule

@@ design/lbua_checker.sv @@
// port-level checks for the lru binding unit allocator, bound to the top level
// depends on lbua_pkg
`timescale 1ns / 1ps
module lbua_port_checker import lbua_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out
);

    // a held result keeps its payload until the transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("result changed before transfer");

    // no evicted id without an eviction
    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.evicted_valid) |-> (o_out.evicted_id == '0))
        else $error("evicted id set without eviction");

    // one request in work at a time
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while another is in work");

    // reset leaves no result pending
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

endmodule

bind lru_binding_unit_allocator lbua_port_checker u_lbua_checker (.*);
